FILE: src/error_code_queue_repeat_reporter_defines.svh
// Assertion macros shared by the error code queue modules.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef ERROR_CODE_QUEUE_REPEAT_REPORTER_DEFINES_SVH
`define ERROR_CODE_QUEUE_REPEAT_REPORTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ECQ_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication, checked outside reset.
`define ECQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

FILE: src/ecqrr_pkg.sv
package ecqrr_pkg;

    localparam int CODE_W   = 32;
    localparam int REPEAT_W = 8;

    localparam logic [REPEAT_W-1:0] REPEAT_RESET = 8'd5;

    // Values of the mode field.
    localparam logic MODE_POST  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] code;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] error_code;
        logic              accepted;
    } out_item_t;

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic post;        // load a post result
        logic push;        // write the code into the queue
        logic repeat_send; // report the current code again
        logic clear;       // queue empty on fetch: drop the current code
        logic pop_load;    // take the popped code as the current code
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic code_nz;
        logic repeat_ok;
    } status_t;

endpackage

FILE: src/error_code_queue_repeat_reporter.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data  (mode, code)
// out       output     out_valid / out_ready   out_data (error_code, accepted)
// cfg       input      cfg_we                  cfg_data (repeat_count)
//
// A post, a repeated fetch and a fetch on an empty queue are answered in the cycle
// after the input transaction; a fetch that pops the queue first passes through the
// S_POP state, because the queue memory has a registered read port.
// One input transaction is in flight at a time, and a new one is taken in the
// same cycle that the previous result is handed off.
// Reset is asynchronous and active low; it empties the queue and sets
// repeat_count to 5. A stalled output holds its result and blocks new input.
module error_code_queue_repeat_reporter #(
    parameter int QUEUE_DEPTH = 5,
    parameter int CODE_BITS   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ecqrr_pkg::in_item_t            in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ecqrr_pkg::out_item_t           out_data,
    input  logic                           cfg_we,
    input  logic [ecqrr_pkg::REPEAT_W-1:0] cfg_data
);

    // Command and status buses between the controller and the datapath.
    ecqrr_pkg::cmd_t    cmd;
    ecqrr_pkg::status_t status;

    // The controller decides what each transaction does from the queue status
    // and sequences the pop through the S_POP state.
    ecqrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (in_data.mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the code queue, the current code with its repeat
    // counter, the repeat_count register and the output register.
    ecqrr_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CODE_BITS   (CODE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .code     (in_data.code),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

FILE: src/ecqrr_ctrl.sv
`include "error_code_queue_repeat_reporter_defines.svh"

module ecqrr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    output logic               out_valid,
    input  logic               out_ready,
    input  ecqrr_pkg::status_t status,
    output ecqrr_pkg::cmd_t    cmd
);

    ecqrr_pkg::state_t state_reg;
    ecqrr_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              in_acc;
    logic              is_fetch;

    // A new transaction is taken only when the output register is free or is
    // being emptied in this cycle.
    assign in_ready  = (state_reg == ecqrr_pkg::S_IDLE) && (!out_valid_reg || out_ready);
    assign in_acc    = in_valid && in_ready;
    assign is_fetch  = (mode == ecqrr_pkg::MODE_FETCH);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ecqrr_pkg::S_IDLE:
            begin
                if (in_acc && is_fetch && !status.repeat_ok && !status.empty)
                begin
                    state_next = ecqrr_pkg::S_POP;
                end
            end
            ecqrr_pkg::S_POP:
            begin
                state_next = ecqrr_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ecqrr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.post        = in_acc && !is_fetch;
        cmd.push        = in_acc && !is_fetch && status.code_nz && !status.full;
        cmd.repeat_send = in_acc && is_fetch && status.repeat_ok;
        cmd.clear       = in_acc && is_fetch && !status.repeat_ok && status.empty;
        cmd.pop_load    = (state_reg == ecqrr_pkg::S_POP);
    end

    always_comb
    begin
        if (cmd.post || cmd.repeat_send || cmd.clear || cmd.pop_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecqrr_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ECQ_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.post, cmd.repeat_send, cmd.clear, cmd.pop_load}))
    `ECQ_ASSERT_IMP(a_pop_out_free, state_reg == ecqrr_pkg::S_POP, !out_valid_reg)
    `ECQ_ASSERT_NEXT(a_pop_result, state_reg == ecqrr_pkg::S_POP, out_valid_reg && state_reg == ecqrr_pkg::S_IDLE)

endmodule

FILE: src/ecqrr_datapath.sv
`include "error_code_queue_repeat_reporter_defines.svh"

module ecqrr_datapath #(
    parameter int QUEUE_DEPTH = 5,
    parameter int CODE_BITS   = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ecqrr_pkg::REPEAT_W-1:0]       cfg_data,
    input  logic [ecqrr_pkg::CODE_W-1:0]         code,
    input  ecqrr_pkg::cmd_t                      cmd,
    output ecqrr_pkg::status_t                   status,
    output ecqrr_pkg::out_item_t                 out_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CODE_BITS-1:0]               mem [QUEUE_DEPTH];
    logic [CODE_BITS-1:0]               rd_data_reg;
    logic [CODE_BITS-1:0]               code_in;
    logic [PTR_W-1:0]                   wr_ptr_reg;
    logic [PTR_W-1:0]                   wr_ptr_next;
    logic [PTR_W-1:0]                   rd_ptr_reg;
    logic [PTR_W-1:0]                   rd_ptr_next;
    logic [CNT_W-1:0]                   fill_reg;
    logic [CNT_W-1:0]                   fill_next;
    logic [CODE_BITS-1:0]               current_reg;
    logic [CODE_BITS-1:0]               current_next;
    logic [ecqrr_pkg::REPEAT_W-1:0]     times_reg;
    logic [ecqrr_pkg::REPEAT_W-1:0]     times_next;
    logic                               sending_reg;
    logic                               sending_next;
    logic [ecqrr_pkg::REPEAT_W-1:0]     repeat_reg;
    ecqrr_pkg::out_item_t               out_data_reg;
    ecqrr_pkg::out_item_t               out_data_next;

    // Only the low CODE_BITS bits of a posted code are kept.
    assign code_in = CODE_BITS'(code);

    assign status.full      = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty     = (fill_reg == '0);
    assign status.code_nz   = (code_in != '0);
    assign status.repeat_ok = sending_reg && (times_reg < repeat_reg);

    assign out_data = out_data_reg;

    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        fill_next     = fill_reg;
        current_next  = current_reg;
        times_next    = times_reg;
        sending_next  = sending_reg;
        out_data_next = out_data_reg;

        if (cmd.post)
        begin
            out_data_next.error_code = '0;
            out_data_next.accepted   = cmd.push;
        end

        if (cmd.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end

        if (cmd.repeat_send)
        begin
            times_next               = times_reg + 1'b1;
            out_data_next.error_code = ecqrr_pkg::CODE_W'(current_reg);
            out_data_next.accepted   = 1'b0;
        end

        if (cmd.clear)
        begin
            current_next  = '0;
            times_next    = '0;
            sending_next  = 1'b0;
            out_data_next = '0;
        end

        // Stored codes are never zero, so a pop always starts a new run.
        if (cmd.pop_load)
        begin
            rd_ptr_next              = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            fill_next                = fill_reg - 1'b1;
            current_next             = rd_data_reg;
            times_next               = ecqrr_pkg::REPEAT_W'(1);
            sending_next             = 1'b1;
            out_data_next.error_code = ecqrr_pkg::CODE_W'(rd_data_reg);
            out_data_next.accepted   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_ptr_reg] <= code_in;
        end
        rd_data_reg  <= mem[rd_ptr_reg];
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            current_reg <= '0;
            times_reg   <= '0;
            sending_reg <= 1'b0;
            repeat_reg  <= ecqrr_pkg::REPEAT_RESET;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            fill_reg    <= fill_next;
            current_reg <= current_next;
            times_reg   <= times_next;
            sending_reg <= sending_next;
            if (cfg_we)
            begin
                repeat_reg <= cfg_data;
            end
        end
    end

    `ECQ_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CNT_W'(QUEUE_DEPTH))
    `ECQ_ASSERT_IMP(a_pop_not_empty, cmd.pop_load, fill_reg != '0)
    `ECQ_ASSERT_NEXT(a_pop_starts_run, cmd.pop_load, sending_reg && times_reg == ecqrr_pkg::REPEAT_W'(1))

endmodule

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Sizes and timing of the bench.
    localparam int QUEUE_DEPTH   = 5;
    localparam int SETTLE_CYCLES = 4;       // a popping fetch passes through S_POP before it answers
    localparam int LONG_HOLD     = 300;     // cycles that the receiver refuses results under pressure
    localparam int CYCLE_LIMIT   = 500000;  // several times the slowest correct run

    // Clock, reset and the block's inputs, all known from time zero.
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    ecqrr_pkg::in_item_t            in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    ecqrr_pkg::out_item_t           out_data;
    logic                           cfg_we    = 1'b0;
    logic [ecqrr_pkg::REPEAT_W-1:0] cfg_data  = '0;

    // Bench-side copy of the queue and the reporting state.
    logic [ecqrr_pkg::CODE_W-1:0]   pending_codes[$];
    logic [ecqrr_pkg::CODE_W-1:0]   shown_code     = '0;
    logic [ecqrr_pkg::REPEAT_W-1:0] shown_count    = '0;
    logic                           showing        = 1'b0;
    logic [ecqrr_pkg::REPEAT_W-1:0] repeat_setting = ecqrr_pkg::REPEAT_RESET;

    // Reports that the block still owes us, oldest first.
    ecqrr_pkg::out_item_t           expected_reports[$];

    // Run control and bookkeeping.
    bit idle_en       = 1'b1;
    bit long_hold_req = 1'b0;
    int mismatch_count     = 0;
    int reports_checked    = 0;
    int posts_sent         = 0;
    int codes_queued       = 0;
    int fetches_sent       = 0;
    int nonzero_reports    = 0;
    int settings_used      = 0;
    int input_stall_cycles = 0;
    int cycle_count        = 0;

    error_code_queue_repeat_reporter #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CODE_BITS   (ecqrr_pkg::CODE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Works out the report for one transaction and advances the bench's copy of the
    // state. A post only touches the queue; a fetch either repeats the code on show
    // or, once it has been reported repeat_setting times, pops the next one. An empty
    // queue on such a pop drops the code on show and reports zero.
    function automatic ecqrr_pkg::out_item_t predict_report(ecqrr_pkg::in_item_t item);
        ecqrr_pkg::out_item_t r;
        r.error_code = '0;
        r.accepted   = 1'b0;
        if (item.mode == ecqrr_pkg::MODE_POST)
        begin
            // Zero codes are never queued, so a popped code is always nonzero.
            if (item.code != '0 && pending_codes.size() < QUEUE_DEPTH)
            begin
                pending_codes.push_back(item.code);
                r.accepted = 1'b1;
            end
        end
        else
        begin
            if (showing && shown_count < repeat_setting)
            begin
                shown_count++;
                r.error_code = shown_code;
            end
            else
            begin
                showing     = 1'b0;
                shown_count = '0;
                shown_code  = '0;
                if (pending_codes.size() != 0)
                begin
                    shown_code   = pending_codes.pop_front();
                    showing      = 1'b1;
                    shown_count  = ecqrr_pkg::REPEAT_W'(1);
                    r.error_code = shown_code;
                end
            end
        end
        return r;
    endfunction

    // Mostly full-width random codes, with zero, all ones and single set bits mixed in.
    function automatic logic [ecqrr_pkg::CODE_W-1:0] random_code();
        logic [ecqrr_pkg::CODE_W-1:0] c;
        case ($urandom_range(0, 9))
            0:       c = '0;
            1:       c = '1;
            2:       c = ecqrr_pkg::CODE_W'(1) << $urandom_range(0, ecqrr_pkg::CODE_W - 1);
            default: c = $urandom();
        endcase
        return c;
    endfunction

    // Offers one transaction and returns at the edge where it is taken. The valid is
    // only lowered when an idle burst comes first, so back-to-back transactions keep
    // it high without a drop within the same time step.
    task automatic send_item(input logic mode, input logic [ecqrr_pkg::CODE_W-1:0] code);
        ecqrr_pkg::in_item_t  item;
        ecqrr_pkg::out_item_t report;
        int                   gap;
        item.mode = mode;
        item.code = code;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // Transactions are taken in order, so predicting at offer time is safe.
        report = predict_report(item);
        expected_reports.push_back(report);
        if (mode == ecqrr_pkg::MODE_POST)
        begin
            posts_sent++;
            if (report.accepted) codes_queued++;
        end
        else
        begin
            fetches_sent++;
            if (report.error_code != '0) nonzero_reports++;
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stops offering and waits until every owed report has been checked, then for
    // SETTLE_CYCLES more so the block is surely idle.
    task automatic drain_reports();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes repeat_count while the block is idle.
    task automatic set_repeat(input logic [ecqrr_pkg::REPEAT_W-1:0] value);
        drain_reports();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        repeat_setting = value;
        settings_used++;
        @(posedge clk);
    endtask

    // Out of reset the register holds 5: one code is reported five times, and the
    // next fetch finds the queue empty and reports zero. A fetch on an empty queue
    // and a posted zero code are both covered first.
    task automatic test_reset_defaults();
        send_item(ecqrr_pkg::MODE_FETCH, '0);
        send_item(ecqrr_pkg::MODE_POST, '0);
        send_item(ecqrr_pkg::MODE_POST, '1);
        repeat (6) send_item(ecqrr_pkg::MODE_FETCH, '0);
        drain_reports();
    endtask

    // Fills the queue to its depth, shows that a further code is dropped and that a
    // zero code is still refused, then drains it with every code reported once. The
    // fetches carry a nonzero code field, which the block must ignore.
    task automatic test_full_queue_single_repeat();
        send_item(ecqrr_pkg::MODE_POST, 32'h0000_0001);
        send_item(ecqrr_pkg::MODE_POST, 32'h8000_0000);
        send_item(ecqrr_pkg::MODE_POST, 32'hA5A5_A5A5);
        send_item(ecqrr_pkg::MODE_POST, 32'h5A5A_5A5A);
        send_item(ecqrr_pkg::MODE_POST, 32'h7FFF_FFFE);
        send_item(ecqrr_pkg::MODE_POST, 32'h0000_0003);
        send_item(ecqrr_pkg::MODE_POST, '0);
        set_repeat(8'd1);
        repeat (6) send_item(ecqrr_pkg::MODE_FETCH, 32'hDEAD_BEEF);
        drain_reports();
    endtask

    // One phase of random traffic under a given repeat_count. The post share decides
    // whether the queue tends to overflow or run dry.
    task automatic test_random_traffic(input logic [ecqrr_pkg::REPEAT_W-1:0] rc,
                                       input int n_items, input int post_pct,
                                       input bit with_idle);
        logic mode;
        set_repeat(rc);
        idle_en = with_idle;
        repeat (n_items)
        begin
            mode = ($urandom_range(0, 99) < post_pct) ? ecqrr_pkg::MODE_POST
                                                       : ecqrr_pkg::MODE_FETCH;
            send_item(mode, random_code());
        end
        drain_reports();
        idle_en = 1'b1;
    endtask

    // The receiver refuses results for a long stretch while the sender keeps
    // offering back to back; the block holds its one result and stalls its input.
    task automatic test_output_backpressure();
        logic mode;
        idle_en       = 1'b0;
        long_hold_req = 1'b1;
        repeat (24)
        begin
            mode = ($urandom_range(0, 1) != 0) ? ecqrr_pkg::MODE_POST : ecqrr_pkg::MODE_FETCH;
            send_item(mode, random_code());
        end
        drain_reports();
        idle_en = 1'b1;
    endtask

    // Checks every handed-off result against the oldest owed report and chooses the
    // ready for the next cycle: random stall bursts, or the long hold when asked.
    initial
    begin : report_checker
        ecqrr_pkg::out_item_t want;
        int                   stall_left;
        int                   hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result with nothing owed: error_code=%h accepted=%b",
                           out_data.error_code, out_data.accepted);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    reports_checked++;
                    if (out_data.error_code !== want.error_code)
                    begin
                        $error("error_code: expected %h, actual %h",
                               want.error_code, out_data.error_code);
                        mismatch_count++;
                    end
                    if (out_data.accepted !== want.accepted)
                    begin
                        $error("accepted: expected %b, actual %b",
                               want.accepted, out_data.accepted);
                        mismatch_count++;
                    end
                end
            end
            if (rst_n && in_valid && !in_ready) input_stall_cycles++;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Ends a run that hangs, for instance on a handshake that never completes.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : test_sequence
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_full_queue_single_repeat();

        // A repeat_count of zero means every fetch pops; 255 is the top of the range.
        test_random_traffic(8'd0,   150, 50, 1'b1);
        test_random_traffic(8'd1,   150, 40, 1'b1);
        test_random_traffic(8'd3,   200, 30, 1'b1);
        test_random_traffic(8'd255, 550,  5, 1'b1);
        test_random_traffic(8'd2,   200, 60, 1'b1);
        test_random_traffic(8'd128, 200, 10, 1'b1);
        test_random_traffic(ecqrr_pkg::REPEAT_RESET, 200, 35, 1'b1);
        test_output_backpressure();

        // The last stretch runs at full rate with no idling on either side, save when a fetch pops.
        test_random_traffic(8'd4,   200, 40, 1'b0);

        drain_reports();
        $display("Covered %0d posts (%0d queued) and %0d fetches (%0d nonzero reports)",
                 posts_sent, codes_queued, fetches_sent, nonzero_reports);
        $display("over %0d repeat_count writes; %0d results checked, %0d input stall cycles",
                 settings_used, reports_checked, input_stall_cycles);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: error_code_queue_repeat_reporter.f
+incdir+src
src/ecqrr_pkg.sv
src/ecqrr_ctrl.sv
src/ecqrr_datapath.sv
src/error_code_queue_repeat_reporter.sv
verif/tb_top.sv
